// File: sv/hapseq_pkg.sv
// ----------------------------------------------------------------------------
// hapseq_pkg
// Shared types, codes and constants for the haptic alert pattern sequencer.
// ----------------------------------------------------------------------------
package hapseq_pkg;

   // Queue depth default
   localparam int QUEUE_DEPTH_DEF = 8;

   // Request kinds (tuser)
   localparam logic [1:0] MODE_TICK    = 2'd0;
   localparam logic [1:0] MODE_RISK    = 2'd1;
   localparam logic [1:0] MODE_PATTERN = 2'd2;

   // Risk levels
   localparam logic [1:0] RISK_CLEAR   = 2'd0;
   localparam logic [1:0] RISK_CAUTION = 2'd1;
   localparam logic [1:0] RISK_WARNING = 2'd2;
   localparam logic [1:0] RISK_DANGER  = 2'd3;

   // Vibration patterns
   localparam logic [1:0] PAT_OFF    = 2'd0;
   localparam logic [1:0] PAT_SINGLE = 2'd1;
   localparam logic [1:0] PAT_DOUBLE = 2'd2;
   localparam logic [1:0] PAT_CONT   = 2'd3;

   // Sequencer phases
   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_SINGLE  = 3'd1;
   localparam logic [2:0] PH_DBL_ON1 = 3'd2;
   localparam logic [2:0] PH_DBL_GAP = 3'd3;
   localparam logic [2:0] PH_DBL_ON2 = 3'd4;

   // Phase lengths in ms ticks
   localparam logic [7:0] SINGLE_MS  = 8'd200;
   localparam logic [7:0] DBL_ON_MS  = 8'd150;
   localparam logic [7:0] DBL_GAP_MS = 8'd100;

   // Relay drive level when on
   localparam logic [7:0] RELAY_ON = 8'hFF;

   // Register indexes
   localparam logic [2:0] CSR_PWM_MODE      = 3'd0;
   localparam logic [2:0] CSR_WARN_COOLDOWN = 3'd1;
   localparam logic [2:0] CSR_DANG_COOLDOWN = 3'd2;
   localparam logic [2:0] CSR_RISK_LIFETIME = 3'd3;
   localparam logic [2:0] CSR_PULSE_DUTY    = 3'd4;
   localparam logic [2:0] CSR_CONT_DUTY     = 3'd5;

   // Register reset values
   localparam logic        RST_PWM_MODE      = 1'b1;
   localparam logic [15:0] RST_WARN_COOLDOWN = 16'd3000;
   localparam logic [15:0] RST_DANG_COOLDOWN = 16'd1000;
   localparam logic [15:0] RST_RISK_LIFETIME = 16'd5000;
   localparam logic [7:0]  RST_PULSE_DUTY    = 8'd200;
   localparam logic [7:0]  RST_CONT_DUTY     = 8'd204;

   // One queued request
   typedef struct packed {
      logic [1:0]  pattern;
      logic [31:0] deadline;
   } q_entry_type;

   // Queue control from the sequencer
   typedef struct packed {
      logic        push;
      logic        pop;
      q_entry_type wr_entry;
   } q_ctrl_type;

   // Queue status to the sequencer
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// File: sv/haptic_alert_pattern_sequencer_unit.sv
// ----------------------------------------------------------------------------
// haptic_alert_pattern_sequencer_unit
// Turns alert requests and millisecond ticks into a vibration motor drive.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request per transfer: tuser selects a tick, a risk
//   level event or a direct pattern; tdata carries the level, pattern and
//   lifetime. rsp_* returns exactly one status result per request: drive
//   duty, motor enable, queued/dropped flags, queue level and playing flag.
//   csr_* writes configuration registers; write only while the unit is idle.
//   The result of a request is registered in the output register, or in the
//   skid register while an earlier result still waits there untaken.
//   Throughput: one request per cycle while the skid register is free. The
//   queue head is read ahead every cycle and memory is written only on a
//   push, so nothing stalls on the memory port. Stalls: an output register
//   plus one skid register hold results; req_tready drops only while the skid
//   register is occupied, i.e. after a request meets a waiting, stalled result.
//   Reset: synchronous; queue empty, sequencer idle, motor off, time zero,
//   cooldowns expired, registers back to their defaults. No clearing pass.
// ----------------------------------------------------------------------------
module haptic_alert_pattern_sequencer_unit #(
   parameter int QUEUE_DEPTH = hapseq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // risk_level[1:0], pattern[3:2], lifetime_ms[19:4], 0 pad
   input  logic [1:0]  req_tuser,   // mode[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // duty[7:0], motor_on[8], accepted[9],
                                    // queue_full_drop[10], queue_level[14:11], playing[15]
   // configuration
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   import hapseq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Configuration registers
   logic        pwm_mode_ff;
   logic [15:0] warn_cd_ms_ff, dang_cd_ms_ff, risk_life_ff;
   logic [7:0]  pulse_duty_ff, cont_duty_ff;

   // Sequencer state
   logic [31:0] time_ff, time_in;
   logic [15:0] warn_left_ff, warn_left_in;
   logic [15:0] dang_left_ff, dang_left_in;
   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  timer_ff, timer_in;
   logic [7:0]  drive_ff, drive_in;

   // Output buffering
   logic        main_valid_ff, skid_valid_ff;
   logic [15:0] main_data_ff, skid_data_ff;

   // Queue interface
   q_ctrl_type      q_ctrl;
   q_entry_type     q_head;
   q_stat_type      q_stat;
   logic [CNT_W-1:0] q_count_in;

   logic        req_fire, rsp_fire;
   logic [1:0]  in_mode, in_level, in_pattern;
   logic [15:0] in_life;
   logic [7:0]  pulse_level, cont_level;
   logic        acc, drop, fresh;
   logic [31:0] left;
   logic [7:0]  t_dec;
   logic [CNT_W+3:0] level_ext;
   logic [15:0] result;

   hapseq_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (q_ctrl),
      .head_entry (q_head),
      .stat       (q_stat),
      .count_in   (q_count_in)
   );

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign in_mode    = req_tuser;
   assign in_level   = req_tdata[1:0];
   assign in_pattern = req_tdata[3:2];
   assign in_life    = req_tdata[19:4];

   // Drive level for a switched-on step
   assign pulse_level = pwm_mode_ff ? pulse_duty_ff : RELAY_ON;
   assign cont_level  = pwm_mode_ff ? cont_duty_ff  : RELAY_ON;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_mode_ff   <= RST_PWM_MODE;
         warn_cd_ms_ff <= RST_WARN_COOLDOWN;
         dang_cd_ms_ff <= RST_DANG_COOLDOWN;
         risk_life_ff  <= RST_RISK_LIFETIME;
         pulse_duty_ff <= RST_PULSE_DUTY;
         cont_duty_ff  <= RST_CONT_DUTY;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PWM_MODE:      pwm_mode_ff   <= csr_wdata[0];
            CSR_WARN_COOLDOWN: warn_cd_ms_ff <= csr_wdata;
            CSR_DANG_COOLDOWN: dang_cd_ms_ff <= csr_wdata;
            CSR_RISK_LIFETIME: risk_life_ff  <= csr_wdata;
            CSR_PULSE_DUTY:    pulse_duty_ff <= csr_wdata[7:0];
            CSR_CONT_DUTY:     cont_duty_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Request processing: enqueue on events, advance and pop on ticks
   always_comb begin
      time_in         = time_ff;
      warn_left_in    = warn_left_ff;
      dang_left_in    = dang_left_ff;
      phase_in        = phase_ff;
      timer_in        = timer_ff;
      drive_in        = drive_ff;
      acc             = 1'b0;
      drop            = 1'b0;
      fresh           = 1'b0;
      left            = q_head.deadline - (time_ff + 32'd1);
      t_dec           = timer_ff - {7'd0, (timer_ff != 8'd0)};
      q_ctrl.push     = 1'b0;
      q_ctrl.pop      = 1'b0;
      q_ctrl.wr_entry.pattern  = in_pattern;
      q_ctrl.wr_entry.deadline = time_ff + {16'd0, in_life};

      if (req_fire) begin
         case (in_mode)
            MODE_TICK: begin
               time_in = time_ff + 32'd1;
               if (warn_left_ff != 16'd0) warn_left_in = warn_left_ff - 16'd1;
               if (dang_left_ff != 16'd0) dang_left_in = dang_left_ff - 16'd1;
               // running pattern steps
               if (phase_ff != PH_IDLE) begin
                  timer_in = t_dec;
                  if (t_dec == 8'd0) begin
                     case (phase_ff)
                        PH_DBL_ON1: begin
                           drive_in = 8'd0;
                           phase_in = PH_DBL_GAP;
                           timer_in = DBL_GAP_MS;
                        end
                        PH_DBL_GAP: begin
                           drive_in = pulse_level;
                           phase_in = PH_DBL_ON2;
                           timer_in = DBL_ON_MS;
                        end
                        default: begin
                           drive_in = 8'd0;
                           phase_in = PH_IDLE;
                        end
                     endcase
                  end
               end
               // idle sequencer takes the next request
               if ((phase_in == PH_IDLE) && !q_stat.empty) begin
                  q_ctrl.pop = 1'b1;
                  fresh = (left[31:16] == 16'd0) && (left != 32'd0);
                  if (fresh) begin
                     case (q_head.pattern)
                        PAT_OFF: drive_in = 8'd0;
                        PAT_SINGLE: begin
                           drive_in = pulse_level;
                           phase_in = PH_SINGLE;
                           timer_in = SINGLE_MS;
                        end
                        PAT_DOUBLE: begin
                           drive_in = pulse_level;
                           phase_in = PH_DBL_ON1;
                           timer_in = DBL_ON_MS;
                        end
                        default: drive_in = cont_level;
                     endcase
                  end
               end
            end
            MODE_RISK: begin
               q_ctrl.wr_entry.pattern  = in_level;
               q_ctrl.wr_entry.deadline = time_ff + {16'd0, risk_life_ff};
               case (in_level)
                  RISK_CAUTION: begin
                     q_ctrl.push = !q_stat.full;
                     acc  = !q_stat.full;
                     drop = q_stat.full;
                  end
                  RISK_WARNING: begin
                     if (warn_left_ff == 16'd0) begin
                        q_ctrl.push = !q_stat.full;
                        acc  = !q_stat.full;
                        drop = q_stat.full;
                        if (!q_stat.full) warn_left_in = warn_cd_ms_ff;
                     end
                  end
                  RISK_DANGER: begin
                     if (dang_left_ff == 16'd0) begin
                        q_ctrl.push = !q_stat.full;
                        acc  = !q_stat.full;
                        drop = q_stat.full;
                        if (!q_stat.full) dang_left_in = dang_cd_ms_ff;
                     end
                  end
                  default: ;
               endcase
            end
            MODE_PATTERN: begin
               q_ctrl.push = !q_stat.full;
               acc  = !q_stat.full;
               drop = q_stat.full;
            end
            default: ;
         endcase
      end
   end

   // Result word
   assign level_ext = {4'd0, q_count_in};
   assign result = {(phase_in != PH_IDLE), level_ext[3:0], drop, acc,
                    (drive_in != 8'd0), (pwm_mode_ff ? drive_in : 8'd0)};

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff      <= '0;
         warn_left_ff <= '0;
         dang_left_ff <= '0;
         phase_ff     <= PH_IDLE;
         timer_ff     <= '0;
         drive_ff     <= '0;
      end else begin
         time_ff      <= time_in;
         warn_left_ff <= warn_left_in;
         dang_left_ff <= dang_left_in;
         phase_ff     <= phase_in;
         timer_ff     <= timer_in;
         drive_ff     <= drive_in;
      end
   end

   // Output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_fire) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_fire) begin
         if (main_valid_ff && !rsp_fire) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end else if (rsp_fire) begin
         main_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_fire) main_data_ff <= skid_data_ff;
      end else if (req_fire) begin
         if (main_valid_ff && !rsp_fire) begin
            skid_data_ff <= result;
         end else begin
            main_data_ff <= result;
         end
      end
   end

   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = main_data_ff;

   // Checks
   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff) else $error("skid holds data ahead of main");
   a_active_timer: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (timer_ff != 8'd0)) else $error("active phase with zero timer");
   a_acc_drop_excl: assert property (@(posedge clock) disable iff (reset)
      !(acc && drop)) else $error("request both queued and dropped");
   a_gap_motor_off: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DBL_GAP) |-> (drive_ff == 8'd0)) else $error("motor on in gap");

endmodule

// File: sv/hapseq_queue.sv
// ----------------------------------------------------------------------------
// hapseq_queue
// Request FIFO in a synchronous memory. The head entry is read ahead every
// cycle, with a bypass when a write lands on the next head slot.
// ----------------------------------------------------------------------------
module hapseq_queue #(
   parameter int QUEUE_DEPTH = hapseq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  hapseq_pkg::q_ctrl_type                ctrl,
   output hapseq_pkg::q_entry_type               head_entry,
   output hapseq_pkg::q_stat_type                stat,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]      count_in
);
   import hapseq_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   q_entry_type             mem [QUEUE_DEPTH];
   q_entry_type             head_q_ff;
   logic [PTR_W-1:0]        head_ff, head_in;
   logic [PTR_W-1:0]        tail_ff, tail_in;
   logic [CNT_W-1:0]        count_ff;

   // Pointer and count update
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (ctrl.pop) begin
         head_in = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
      end
      if (ctrl.push) begin
         tail_in = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
      end
      case ({ctrl.push, ctrl.pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Memory write and head read-ahead with write bypass
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[tail_ff] <= ctrl.wr_entry;
      end
      if (ctrl.push && (tail_ff == head_in)) begin
         head_q_ff <= ctrl.wr_entry;
      end else begin
         head_q_ff <= mem[head_in];
      end
   end

   assign head_entry = head_q_ff;
   assign stat.full  = (count_ff == FULL_CNT);
   assign stat.empty = (count_ff == '0);

   // Checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT) else $error("queue count beyond depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |-> !stat.full) else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |-> !stat.empty) else $error("pop from empty queue");

endmodule

// File: dv/hapseq_status_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hapseq_status_checker
// Watches the request, result and register ports of the haptic sequencer and
// keeps a model of its queue, cooldowns, pattern timing and drive level. Each
// accepted request yields one predicted status word. Each accepted result is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module hapseq_status_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // risk_level[1:0], pattern[3:2], lifetime_ms[19:4], 0 pad
   input  logic [1:0]  req_tuser,   // mode[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // duty[7:0], motor_on[8], accepted[9],
                                    // queue_full_drop[10], queue_level[14:11], playing[15]
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata,
   output int          mismatch_count,
   output int          pending_results,
   output int          n_checked,
   output int          n_queued,
   output int          n_full_drops,
   output int          n_stale,
   output int          n_started
);
   import hapseq_pkg::*;

   localparam int QDEPTH = QUEUE_DEPTH_DEF;

   // Status word, laid out as on rsp_tdata
   typedef struct packed {
      logic       playing;
      logic [3:0] queue_level;
      logic       full_drop;
      logic       accepted;
      logic       motor_on;
      logic [7:0] duty;
   } status_type;

   // Register copies
   logic        pwm_mode;
   logic [15:0] warn_cooldown;
   logic [15:0] dang_cooldown;
   logic [15:0] risk_lifetime;
   logic [7:0]  pulse_duty;
   logic [7:0]  cont_duty;

   // Sequencer state
   logic [31:0] time_now;
   logic [1:0]  q_pattern [QDEPTH];
   logic [31:0] q_deadline [QDEPTH];
   int          queue_head;
   int          queue_tail;
   int          queue_count;
   logic [15:0] warn_left;
   logic [15:0] dang_left;
   logic [2:0]  seq_phase;
   logic [7:0]  phase_timer;
   logic [7:0]  drive_level;

   status_type  expected_status [$];

   initial begin
      mismatch_count = 0;
      pending_results = 0;
      n_checked = 0;
      n_queued = 0;
      n_full_drops = 0;
      n_stale = 0;
      n_started = 0;
   end

   function automatic logic [7:0] on_level(input logic [7:0] duty);
      return pwm_mode ? duty : RELAY_ON;
   endfunction

   // Queue a request; 0 when the queue is full
   function automatic logic enqueue_alert(input logic [1:0] pat, input logic [15:0] life);
      if (queue_count >= QDEPTH) return 1'b0;
      q_pattern[queue_tail] = pat;
      q_deadline[queue_tail] = time_now + 32'(life);
      queue_tail = (queue_tail + 1) % QDEPTH;
      queue_count++;
      return 1'b1;
   endfunction

   // Apply one request to the model and return its status word
   function automatic status_type predict_status(input logic [1:0] kind,
                                                 input logic [23:0] data);
      logic [1:0]  risk;
      logic [1:0]  pat;
      logic [15:0] life;
      logic [31:0] left;
      status_type  st;
      risk = data[1:0];
      pat = data[3:2];
      life = data[19:4];
      st = '0;
      case (kind)
         MODE_TICK: begin
            time_now = time_now + 32'd1;
            if (warn_left != 0) warn_left--;
            if (dang_left != 0) dang_left--;
            // running pattern steps on
            if (seq_phase != PH_IDLE) begin
               if (phase_timer != 0) phase_timer--;
               if (phase_timer == 0) begin
                  case (seq_phase)
                     PH_DBL_ON1: begin
                        drive_level = '0;
                        seq_phase = PH_DBL_GAP;
                        phase_timer = DBL_GAP_MS;
                     end
                     PH_DBL_GAP: begin
                        drive_level = on_level(pulse_duty);
                        seq_phase = PH_DBL_ON2;
                        phase_timer = DBL_ON_MS;
                     end
                     default: begin
                        drive_level = '0;
                        seq_phase = PH_IDLE;
                     end
                  endcase
               end
            end
            // idle sequencer pops the head; stale requests are discarded
            if (seq_phase == PH_IDLE && queue_count > 0) begin
               pat = q_pattern[queue_head];
               left = q_deadline[queue_head] - time_now;
               queue_head = (queue_head + 1) % QDEPTH;
               queue_count--;
               if (left != 0 && left <= 32'h0000_FFFF) begin
                  if (pat != PAT_OFF) n_started++;
                  case (pat)
                     PAT_OFF: drive_level = '0;
                     PAT_SINGLE: begin
                        drive_level = on_level(pulse_duty);
                        seq_phase = PH_SINGLE;
                        phase_timer = SINGLE_MS;
                     end
                     PAT_DOUBLE: begin
                        drive_level = on_level(pulse_duty);
                        seq_phase = PH_DBL_ON1;
                        phase_timer = DBL_ON_MS;
                     end
                     default: drive_level = on_level(cont_duty);
                  endcase
               end else begin
                  n_stale++;
               end
            end
         end
         MODE_RISK: begin
            case (risk)
               RISK_CAUTION: begin
                  if (enqueue_alert(PAT_SINGLE, risk_lifetime)) st.accepted = 1'b1;
                  else st.full_drop = 1'b1;
               end
               RISK_WARNING: begin
                  // cooldown charged only when actually queued
                  if (warn_left == 0) begin
                     if (enqueue_alert(PAT_DOUBLE, risk_lifetime)) begin
                        st.accepted = 1'b1;
                        warn_left = warn_cooldown;
                     end else begin
                        st.full_drop = 1'b1;
                     end
                  end
               end
               RISK_DANGER: begin
                  if (dang_left == 0) begin
                     if (enqueue_alert(PAT_CONT, risk_lifetime)) begin
                        st.accepted = 1'b1;
                        dang_left = dang_cooldown;
                     end else begin
                        st.full_drop = 1'b1;
                     end
                  end
               end
               default: ;
            endcase
         end
         MODE_PATTERN: begin
            if (enqueue_alert(pat, life)) st.accepted = 1'b1;
            else st.full_drop = 1'b1;
         end
         default: ;
      endcase
      st.duty = pwm_mode ? drive_level : 8'd0;
      st.motor_on = (drive_level != 0);
      st.queue_level = 4'(queue_count);
      st.playing = (seq_phase != PH_IDLE);
      return st;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      mismatch_count++;
      $display("[%0t] status result %0d: %s got %0d, want %0d",
               $realtime, n_checked, field, got, want);
   endtask

   // Track registers and requests, compare results
   always @(posedge clock) begin
      status_type got;
      status_type want;
      if (reset) begin
         pwm_mode = RST_PWM_MODE;
         warn_cooldown = RST_WARN_COOLDOWN;
         dang_cooldown = RST_DANG_COOLDOWN;
         risk_lifetime = RST_RISK_LIFETIME;
         pulse_duty = RST_PULSE_DUTY;
         cont_duty = RST_CONT_DUTY;
         time_now = '0;
         queue_head = 0;
         queue_tail = 0;
         queue_count = 0;
         warn_left = '0;
         dang_left = '0;
         seq_phase = PH_IDLE;
         phase_timer = '0;
         drive_level = '0;
         expected_status.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_PWM_MODE:      pwm_mode = csr_wdata[0];
               CSR_WARN_COOLDOWN: warn_cooldown = csr_wdata;
               CSR_DANG_COOLDOWN: dang_cooldown = csr_wdata;
               CSR_RISK_LIFETIME: risk_lifetime = csr_wdata;
               CSR_PULSE_DUTY:    pulse_duty = csr_wdata[7:0];
               CSR_CONT_DUTY:     cont_duty = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            want = predict_status(req_tuser, req_tdata);
            n_queued += want.accepted;
            n_full_drops += want.full_drop;
            expected_status.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_status.size() == 0) begin
               report_mismatch("unexpected result, tdata", int'(rsp_tdata), 0);
            end else begin
               want = expected_status.pop_front();
               if (got.duty !== want.duty) report_mismatch("duty", got.duty, want.duty);
               if (got.motor_on !== want.motor_on)
                  report_mismatch("motor_on", got.motor_on, want.motor_on);
               if (got.accepted !== want.accepted)
                  report_mismatch("accepted", got.accepted, want.accepted);
               if (got.full_drop !== want.full_drop)
                  report_mismatch("queue_full_drop", got.full_drop, want.full_drop);
               if (got.queue_level !== want.queue_level)
                  report_mismatch("queue_level", got.queue_level, want.queue_level);
               if (got.playing !== want.playing)
                  report_mismatch("playing", got.playing, want.playing);
            end
            n_checked++;
         end
      end
      pending_results = expected_status.size();
   end

endmodule

// File: dv/haptic_alert_pattern_sequencer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// haptic_alert_pattern_sequencer_unit_tb
// Drives ticks, risk events and direct pattern requests into the haptic
// sequencer under four register settings with random stalls on both sides.
// A status checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module haptic_alert_pattern_sequencer_unit_tb;
   import hapseq_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int ITEMS_PER_PHASE = 500;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = MODE_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = CSR_PWM_MODE;
   logic [15:0] csr_wdata = '0;

   int mismatch_count;
   int pending_results;
   int n_checked;
   int n_queued;
   int n_full_drops;
   int n_stale;
   int n_started;
   int send_idle_pct = 0;
   int rcv_idle_pct = 0;
   int cycle_count = 0;

   always #4 clock = ~clock;

   haptic_alert_pattern_sequencer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   hapseq_status_checker u_status_check (.*);

   // Result side back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
   end

   // Run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("haptic_alert_pattern_sequencer_unit regression: fail");
         $finish;
      end
   end

   function automatic logic [23:0] pack_req(input logic [1:0] risk, input logic [1:0] pat,
                                            input logic [15:0] life);
      return {4'd0, life, pat, risk};
   endfunction

   // Present one request with optional leading gap; returns on the falling
   // edge after acceptance
   task automatic send_req(input logic [1:0] kind, input logic [23:0] data);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Hold off until every outstanding result is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_regs(input logic pwm, input logic [15:0] warn_cd,
                             input logic [15:0] dang_cd, input logic [15:0] life,
                             input logic [7:0] pulse, input logic [7:0] cont);
      csr_we <= 1'b1;
      csr_addr <= CSR_PWM_MODE;
      csr_wdata <= {15'd0, pwm};
      @(negedge clock);
      csr_addr <= CSR_WARN_COOLDOWN;
      csr_wdata <= warn_cd;
      @(negedge clock);
      csr_addr <= CSR_DANG_COOLDOWN;
      csr_wdata <= dang_cd;
      @(negedge clock);
      csr_addr <= CSR_RISK_LIFETIME;
      csr_wdata <= life;
      @(negedge clock);
      csr_addr <= CSR_PULSE_DUTY;
      csr_wdata <= {8'd0, pulse};
      @(negedge clock);
      csr_addr <= CSR_CONT_DUTY;
      csr_wdata <= {8'd0, cont};
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Tick-heavy random mix so patterns play through; lifetimes mostly short
   task automatic run_random(input int count, input bit hold_midway);
      for (int i = 0; i < count; i++) begin
         int          pick;
         int          lsel;
         logic [15:0] life;
         logic [1:0]  kind;
         if (hold_midway && i == count / 2) drain_results();
         pick = $urandom_range(0, 99);
         lsel = $urandom_range(0, 9);
         life = (lsel == 0) ? 16'd0 :
                (lsel < 6)  ? 16'($urandom_range(1, 700)) : 16'($urandom);
         kind = (pick < 72) ? MODE_TICK :
                (pick < 84) ? MODE_RISK :
                (pick < 97) ? MODE_PATTERN : MODE_UNUSED;
         send_req(kind, pack_req(2'($urandom), 2'($urandom), life));
      end
   endtask

   initial begin
      send_idle_pct = 8;
      rcv_idle_pct = 55;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed: reset defaults, every kind, cooldown rejects, full queue
      send_req(MODE_UNUSED, pack_req(2'd3, 2'd3, 16'hFFFF));
      send_req(MODE_RISK, pack_req(RISK_CLEAR, PAT_OFF, 16'd0));
      send_req(MODE_RISK, pack_req(RISK_CAUTION, PAT_OFF, 16'd0));
      send_req(MODE_RISK, pack_req(RISK_WARNING, PAT_OFF, 16'd0));
      send_req(MODE_RISK, pack_req(RISK_WARNING, PAT_CONT, 16'hFFFF));
      send_req(MODE_RISK, pack_req(RISK_DANGER, PAT_OFF, 16'd0));
      send_req(MODE_RISK, pack_req(RISK_DANGER, PAT_OFF, 16'd0));
      send_req(MODE_PATTERN, pack_req(RISK_CLEAR, PAT_OFF, 16'd0));
      send_req(MODE_PATTERN, pack_req(RISK_CLEAR, PAT_SINGLE, 16'hFFFF));
      send_req(MODE_PATTERN, pack_req(RISK_CLEAR, PAT_DOUBLE, 16'd1));
      send_req(MODE_PATTERN, pack_req(RISK_CLEAR, PAT_CONT, 16'hFFFF));
      send_req(MODE_PATTERN, pack_req(RISK_CLEAR, PAT_SINGLE, 16'h8000));
      // queue now full
      send_req(MODE_PATTERN, pack_req(RISK_CLEAR, PAT_DOUBLE, 16'd7));
      send_req(MODE_RISK, pack_req(RISK_CAUTION, PAT_OFF, 16'd0));
      send_req(MODE_RISK, pack_req(RISK_DANGER, PAT_OFF, 16'd0));
      for (int i = 0; i < 6; i++) send_req(MODE_TICK, pack_req(2'd3, 2'd3, 16'hFFFF));
      drain_results();

      // PWM, short cooldowns, zero pulse duty, full continuous duty
      write_regs(1'b1, 16'd40, 16'd0, 16'd300, 8'd0, 8'd255);
      run_random(ITEMS_PER_PHASE, 1'b0);
      drain_results();

      // Relay drive, longest danger cooldown and risk lifetime
      send_idle_pct = 55;
      rcv_idle_pct = 8;
      write_regs(1'b0, 16'd0, 16'hFFFF, 16'hFFFF, 8'd128, 8'd77);
      run_random(ITEMS_PER_PHASE, 1'b0);
      drain_results();

      // PWM, longest warning cooldown, risk requests stale on arrival
      send_idle_pct = 0;
      rcv_idle_pct = 0;
      write_regs(1'b1, 16'hFFFF, 16'd25, 16'd0, 8'd255, 8'd0);
      run_random(ITEMS_PER_PHASE, 1'b1);
      drain_results();

      $display("Checked %0d status results under reset defaults and three register sets;",
               n_checked);
      $display("%0d requests queued, %0d full-queue drops, %0d stale discards, %0d patterns started.",
               n_queued, n_full_drops, n_stale, n_started);
      if (mismatch_count == 0) begin
         $display("haptic_alert_pattern_sequencer_unit regression: pass");
      end else begin
         $display("haptic_alert_pattern_sequencer_unit regression: fail");
      end
      $finish;
   end

endmodule
